// ----- rtl/core/pcdm_pkg.sv -----
// shared constants and control types for the peripheral clock divider
`default_nettype none

package pcdm_pkg;

    // cycle count width taken from each input beat
    localparam int CYCLE_WIDTH = 16;
    localparam int CYCLES_W    = 16;
    // count bits used from the port, never more than the port carries
    localparam int CYC_USE_W   = (CYCLE_WIDTH < CYCLES_W) ? CYCLE_WIDTH : CYCLES_W;
    localparam int MOVE_W      = 8;
    localparam int SPEED_W     = 8;
    localparam int PEND_W      = 16;

    // result field widths
    localparam int VIA_W   = 13;
    localparam int SCC_W   = 16;
    localparam int KBD_W   = 17;
    localparam int RTC_W   = 17;
    localparam int LINES_W = 3;

    // state widths
    localparam int VIA_ACC_W = 4;
    localparam int KBD_ACC_W = 8;
    localparam int RTC_ACC_W = 13;
    localparam int SCC_PH_W  = 5;

    // cascade constants
    localparam int VIA_STEP   = 10;
    localparam int KBD_LIMIT  = 256;
    localparam int RTC_LIMIT  = 8192;
    localparam int PEND_STEP  = 2;

    // remainder plus count, and the serial division length
    localparam int SUM_W      = CYC_USE_W + 1;
    localparam int STEP_CNT_W = $clog2(SUM_W + 1);

    // divide by ten through a reciprocal, exact for values below 2**(SUM_W+1)
    localparam int RECIP_SHIFT = SUM_W + 4;
    localparam int RECIP_W     = SUM_W + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int VIA_Q_W = PROD_W - RECIP_SHIFT;

    // intermediate cascade widths
    localparam int K2_W = SUM_W + 1;
    localparam int PH_W = K2_W + 4;
    localparam int R3_W = K2_W + 1;

    // line reset: button line high, phases low
    localparam logic [LINES_W-1:0] LINES_RESET = 3'b001;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/core/pcdm_if.sv -----
// valid/ready channel interfaces for input and result beats
`default_nettype none

interface pcdm_in_if;
    logic                                valid;
    logic                                ready;
    logic [pcdm_pkg::CYCLES_W-1:0]       cycles;
    logic signed [pcdm_pkg::MOVE_W-1:0]  move_x;
    logic signed [pcdm_pkg::MOVE_W-1:0]  move_y;
    logic                                button;

    modport source (output valid, output cycles, output move_x, output move_y,
                    output button, input ready);
    modport sink   (input valid, input cycles, input move_x, input move_y,
                    input button, output ready);
endinterface

interface pcdm_out_if;
    logic                              valid;
    logic                              ready;
    logic [pcdm_pkg::VIA_W-1:0]        via_ticks;
    logic [pcdm_pkg::SCC_W-1:0]        scc_ticks;
    logic [pcdm_pkg::KBD_W-1:0]        kbd_ticks;
    logic [pcdm_pkg::RTC_W-1:0]        rtc_ticks;
    logic [pcdm_pkg::LINES_W-1:0]      mouse_lines;
    logic                              dcd_x_strobe;
    logic                              dcd_x_level;
    logic                              dcd_y_strobe;
    logic                              dcd_y_level;

    modport source (output valid, output via_ticks, output scc_ticks,
                    output kbd_ticks, output rtc_ticks, output mouse_lines,
                    output dcd_x_strobe, output dcd_x_level,
                    output dcd_y_strobe, output dcd_y_level, input ready);
    modport sink   (input valid, input via_ticks, input scc_ticks,
                    input kbd_ticks, input rtc_ticks, input mouse_lines,
                    input dcd_x_strobe, input dcd_x_level,
                    input dcd_y_strobe, input dcd_y_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pcdm_ctrl.sv -----
// sequencer: accept, serial divide, reciprocal multiply, cascade and result load
`default_nettype none

module pcdm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pcdm_pkg::t_dp_status i_status,
    output pcdm_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic [pcdm_pkg::STEP_CNT_W-1:0]     r_cnt, n_cnt;
    logic                                last_step;

    assign o_in_ready = (r_state == ST_IDLE);
    assign last_step  = (r_cnt == pcdm_pkg::STEP_CNT_W'(pcdm_pkg::SUM_W - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (last_step) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // wait for the result slot to free up
                if (!i_status.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DIV))
        else $error("accepted beat did not start division");

    a_mul_after_full_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |->
            ($past(r_state) == ST_DIV &&
             $past(r_cnt) == pcdm_pkg::STEP_CNT_W'(pcdm_pkg::SUM_W - 1)))
        else $error("multiply entered before all quotient bits");

    a_finish_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> !i_status.out_full)
        else $error("result loaded over a stalled beat");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.div_step, o_cmd.mul, o_cmd.finish}))
        else $error("more than one datapath command");

endmodule

`default_nettype wire

// ----- rtl/core/pcdm_dp.sv -----
// datapath: divider, tick cascade, mouse encoder and result register
`default_nettype none

module pcdm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pcdm_pkg::t_dp_cmd                   i_cmd,
    output pcdm_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_we,
    input  logic [pcdm_pkg::SPEED_W-1:0]        i_cfg_wdata,
    input  logic [pcdm_pkg::CYCLES_W-1:0]       i_cycles,
    input  logic signed [pcdm_pkg::MOVE_W-1:0]  i_move_x,
    input  logic signed [pcdm_pkg::MOVE_W-1:0]  i_move_y,
    input  logic                                i_button,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pcdm_pkg::VIA_W-1:0]          o_via_ticks,
    output logic [pcdm_pkg::SCC_W-1:0]          o_scc_ticks,
    output logic [pcdm_pkg::KBD_W-1:0]          o_kbd_ticks,
    output logic [pcdm_pkg::RTC_W-1:0]          o_rtc_ticks,
    output logic [pcdm_pkg::LINES_W-1:0]        o_mouse_lines,
    output logic                                o_dcd_x_strobe,
    output logic                                o_dcd_x_level,
    output logic                                o_dcd_y_strobe,
    output logic                                o_dcd_y_level
);

    localparam int SW = pcdm_pkg::SPEED_W;
    localparam int PW = pcdm_pkg::PEND_W;

    // saturating add of a motion byte into a pending delta
    function automatic logic signed [PW-1:0] sat_add(
        input logic signed [PW-1:0]               acc,
        input logic signed [pcdm_pkg::MOVE_W-1:0] mv
    );
        logic signed [PW:0] s;
        s = (PW+1)'(acc) + (PW+1)'(mv);
        if (s[PW] != s[PW-1]) begin
            sat_add = s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
            sat_add = s[PW-1:0];
        end
    endfunction

    // architectural state
    logic [SW-1:0]                          r_speed;
    logic [SW-1:0]                          r_rem;
    logic [pcdm_pkg::VIA_ACC_W-1:0]         r_via_acc;
    logic [pcdm_pkg::KBD_ACC_W-1:0]         r_kbd_acc;
    logic [pcdm_pkg::RTC_ACC_W-1:0]         r_rtc_acc;
    logic [pcdm_pkg::SCC_PH_W-1:0]          r_scc_ph;
    logic signed [PW-1:0]                   r_pend_x;
    logic signed [PW-1:0]                   r_pend_y;
    logic                                   r_button;
    logic [pcdm_pkg::LINES_W-1:0]           r_lines;
    logic                                   r_xdcd;
    logic                                   r_ydcd;

    // working registers
    logic [pcdm_pkg::SUM_W-1:0]             r_quo;
    logic [pcdm_pkg::SUM_W-1:0]             r_v1;
    logic [pcdm_pkg::PROD_W-1:0]            r_prod;
    logic                                   r_out_valid;

    logic [SW-1:0]                          divisor;
    logic [pcdm_pkg::SUM_W-1:0]             sum;
    logic [SW:0]                            trial;
    logic                                   ge;
    logic [pcdm_pkg::SUM_W-1:0]             v1;

    logic [pcdm_pkg::VIA_Q_W-1:0]           via;
    logic [pcdm_pkg::SUM_W-1:0]             via10;
    logic [pcdm_pkg::K2_W-1:0]              k2;
    logic [pcdm_pkg::PH_W-1:0]              ph;
    logic [pcdm_pkg::R3_W-1:0]              r3;
    logic                                   reach_scc;
    logic                                   reach_rtc;
    logic                                   step_x;
    logic                                   step_y;
    logic [pcdm_pkg::LINES_W-1:0]           lines_enc;
    logic [pcdm_pkg::LINES_W-1:0]           lines_new;

    assign divisor = (r_speed == '0) ? SW'(1) : r_speed;
    assign sum = pcdm_pkg::SUM_W'(r_rem)
               + pcdm_pkg::SUM_W'(i_cycles[pcdm_pkg::CYC_USE_W-1:0]);

    // one restoring division step per cycle
    assign trial = {r_rem, r_quo[pcdm_pkg::SUM_W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    assign v1 = r_quo + pcdm_pkg::SUM_W'(r_via_acc);

    // cascade on the registered quotient
    assign via   = r_prod[pcdm_pkg::PROD_W-1:pcdm_pkg::RECIP_SHIFT];
    assign via10 = {via, 3'b000} + pcdm_pkg::SUM_W'({via, 1'b0});
    assign k2    = pcdm_pkg::K2_W'(r_kbd_acc) + pcdm_pkg::K2_W'(via10);
    // phase plus 15 times k2
    assign ph    = pcdm_pkg::PH_W'(r_scc_ph) + {k2, 4'b0000} - pcdm_pkg::PH_W'(k2);
    assign r3    = pcdm_pkg::R3_W'(r_rtc_acc) + pcdm_pkg::R3_W'(k2);

    assign reach_scc = (via != '0) && (k2 >= pcdm_pkg::K2_W'(pcdm_pkg::KBD_LIMIT));
    assign reach_rtc = reach_scc && (r3 >= pcdm_pkg::R3_W'(pcdm_pkg::RTC_LIMIT));

    // encoder steps when the delta is at least two either way
    assign step_x = (r_pend_x >= PW'(pcdm_pkg::PEND_STEP))
                 || (r_pend_x <= -PW'(pcdm_pkg::PEND_STEP));
    assign step_y = (r_pend_y >= PW'(pcdm_pkg::PEND_STEP))
                 || (r_pend_y <= -PW'(pcdm_pkg::PEND_STEP));

    always_comb begin
        lines_enc    = r_lines;
        lines_enc[0] = ~r_button;
        if (step_x) begin
            lines_enc[1] = (r_pend_x > 0) ? r_xdcd : ~r_xdcd;
        end
        if (step_y) begin
            lines_enc[2] = (r_pend_y > 0) ? ~r_ydcd : r_ydcd;
        end
    end

    assign lines_new = reach_rtc ? lines_enc : r_lines;

    assign o_status.out_full = r_out_valid && !i_ready;
    assign o_valid           = r_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= SW'(1);
            r_rem     <= '0;
            r_via_acc <= '0;
            r_kbd_acc <= '0;
            r_rtc_acc <= '0;
            r_scc_ph  <= '0;
            r_pend_x  <= '0;
            r_pend_y  <= '0;
            r_button  <= 1'b0;
            r_lines   <= pcdm_pkg::LINES_RESET;
            r_xdcd    <= 1'b0;
            r_ydcd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_speed <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_rem    <= '0;
                r_pend_x <= sat_add(r_pend_x, i_move_x);
                r_pend_y <= sat_add(r_pend_y, i_move_y);
                r_button <= i_button;
            end
            if (i_cmd.div_step) begin
                r_rem <= ge ? SW'(trial - {1'b0, divisor}) : trial[SW-1:0];
            end
            if (i_cmd.finish) begin
                r_via_acc <= pcdm_pkg::VIA_ACC_W'(r_v1 - via10);
                if (via != '0) begin
                    if (!reach_scc) begin
                        r_kbd_acc <= k2[pcdm_pkg::KBD_ACC_W-1:0];
                    end else begin
                        r_scc_ph  <= ph[pcdm_pkg::SCC_PH_W-1:0];
                        r_kbd_acc <= '0;
                        if (!reach_rtc) begin
                            r_rtc_acc <= r3[pcdm_pkg::RTC_ACC_W-1:0];
                        end else begin
                            r_rtc_acc <= '0;
                            r_lines   <= lines_enc;
                            if (step_x) begin
                                r_xdcd   <= ~r_xdcd;
                                r_pend_x <= (r_pend_x > 0)
                                          ? r_pend_x - PW'(pcdm_pkg::PEND_STEP)
                                          : r_pend_x + PW'(pcdm_pkg::PEND_STEP);
                            end
                            if (step_y) begin
                                r_ydcd   <= ~r_ydcd;
                                r_pend_y <= (r_pend_y > 0)
                                          ? r_pend_y - PW'(pcdm_pkg::PEND_STEP)
                                          : r_pend_y + PW'(pcdm_pkg::PEND_STEP);
                            end
                        end
                    end
                end
            end
            priority if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= sum;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[pcdm_pkg::SUM_W-2:0], ge};
        end
        if (i_cmd.mul) begin
            r_v1   <= v1;
            r_prod <= pcdm_pkg::PROD_W'(v1) * pcdm_pkg::PROD_W'(pcdm_pkg::RECIP);
        end
        if (i_cmd.finish) begin
            o_via_ticks    <= pcdm_pkg::VIA_W'(via);
            o_scc_ticks    <= reach_scc ? pcdm_pkg::SCC_W'(ph >> pcdm_pkg::SCC_PH_W) : '0;
            o_kbd_ticks    <= reach_scc ? pcdm_pkg::KBD_W'(k2) : '0;
            o_rtc_ticks    <= reach_rtc ? pcdm_pkg::RTC_W'(r3) : '0;
            o_mouse_lines  <= lines_new;
            o_dcd_x_strobe <= reach_rtc && step_x;
            o_dcd_x_level  <= reach_rtc && step_x && r_xdcd;
            o_dcd_y_strobe <= reach_rtc && step_y;
            o_dcd_y_level  <= reach_rtc && step_y && r_ydcd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/peripheral_clock_divider_mouse_unit.sv -----
// top level of the peripheral clock divider with quadrature mouse encoder
`default_nettype none

// usage
// - i_in carries one beat per cpu step: cycle count, x/y motion and button
//   level; o_out returns exactly one result beat for each input beat
// - i_cfg_we / i_cfg_wdata write the speed factor (reset value 1, 0 acts as
//   1); write it only while no beat is in flight
// - the cycle count plus the held remainder is divided by the speed factor
//   one quotient bit per clock, then the item passes through the divide-by-ten
//   multiply and the tick cascade
// - i_in takes no new beat while one is in flight in the divider; i_in is
//   ready again the cycle after the result is loaded
// - the result sits in an output register, so a new input beat is taken
//   while the previous result is still waiting
// - if the receiver stalls with a result still held, the finished item waits
//   in the cascade stage and i_in stays not ready until the slot frees
// - reset (synchronous, active low) clears all accumulators and pending
//   deltas, sets the button line high and both phase lines low, and empties
//   the output register

module peripheral_clock_divider_mouse_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pcdm_in_if.sink                       i_in,
    pcdm_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [pcdm_pkg::SPEED_W-1:0]  i_cfg_wdata
);

    pcdm_pkg::t_dp_cmd    cmd;
    pcdm_pkg::t_dp_status status;
    logic                 in_ready;

    assign i_in.ready = in_ready;

    // sequencer: owns the handshake on the input side
    pcdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // divider, tick cascade, encoder and output register
    pcdm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cycles       (i_in.cycles),
        .i_move_x       (i_in.move_x),
        .i_move_y       (i_in.move_y),
        .i_button       (i_in.button),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_via_ticks    (o_out.via_ticks),
        .o_scc_ticks    (o_out.scc_ticks),
        .o_kbd_ticks    (o_out.kbd_ticks),
        .o_rtc_ticks    (o_out.rtc_ticks),
        .o_mouse_lines  (o_out.mouse_lines),
        .o_dcd_x_strobe (o_out.dcd_x_strobe),
        .o_dcd_x_level  (o_out.dcd_x_level),
        .o_dcd_y_strobe (o_out.dcd_y_strobe),
        .o_dcd_y_level  (o_out.dcd_y_level)
    );

endmodule

`default_nettype wire
